// ----- rtl/maes_pkg.sv -----
// Shared types, tables and GF(2^8) helpers for the modified AES-128 cipher.
// No dependencies; used by maes_round and the top level.
package maes_pkg;

   typedef struct packed {
      logic        cmd;
      logic [63:0] block_high;
      logic [63:0] block_low;
   } req_type;

   typedef struct packed {
      logic [63:0] result_high;
      logic [63:0] result_low;
   } rsp_type;

   typedef struct packed {
      logic decrypt;
      logic key_only;
      logic skip_mix;
   } round_ctrl_type;

   localparam int unsigned NumRoundKeys = 11;
   localparam int unsigned RkAddrWidth  = $clog2(NumRoundKeys);
   localparam logic [RkAddrWidth-1:0] LastRound = RkAddrWidth'(NumRoundKeys - 1);

   localparam logic [0:0] CSR_KEY_HIGH = 1'b0;
   localparam logic [0:0] CSR_KEY_LOW  = 1'b1;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] sbox(input logic [7:0] x);
      return SBOX[x];
   endfunction

   // inverse lookup; reduces to a constant table in synthesis
   function automatic logic [7:0] inv_sbox(input logic [7:0] y);
      logic [7:0] r;
      r = 8'h00;
      for (int v = 0; v < 256; v++) begin
         if (SBOX[v] == y) r = 8'(v);
      end
      return r;
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] x;
      logic [7:0] acc;
      x = {1'b0, a};
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc = acc ^ x[7:0];
         x = {x[7:0], 1'b0};
         if (x[8]) x = x ^ 9'h11b;
      end
      return acc;
   endfunction

   function automatic logic [31:0] rcon(input logic [RkAddrWidth-1:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0: c = 8'h01;
         4'd1: c = 8'h02;
         4'd2: c = 8'h04;
         4'd3: c = 8'h08;
         4'd4: c = 8'h10;
         4'd5: c = 8'h20;
         4'd6: c = 8'h40;
         4'd7: c = 8'h80;
         4'd8: c = 8'h1b;
         4'd9: c = 8'h36;
         default: c = 8'h00;
      endcase
      return {c, 24'h000000};
   endfunction

   // round key idx+1 from round key idx
   function automatic logic [127:0] next_round_key(input logic [127:0] rk,
                                                   input logic [RkAddrWidth-1:0] idx);
      logic [31:0] w0, w1, w2, w3, t, rot;
      w0  = rk[127:96];
      w1  = rk[95:64];
      w2  = rk[63:32];
      w3  = rk[31:0];
      rot = {w3[23:0], w3[31:24]};
      t   = {sbox(rot[31:24]), sbox(rot[23:16]), sbox(rot[15:8]), sbox(rot[7:0])} ^ rcon(idx);
      w0  = w0 ^ t;
      w1  = w1 ^ w0;
      w2  = w2 ^ w1;
      w3  = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   function automatic logic [RkAddrWidth-1:0] key_index(input logic decrypt,
                                                        input logic [RkAddrWidth-1:0] step);
      return decrypt ? LastRound - step : step;
   endfunction

endpackage

// ----- rtl/maes_round.sv -----
// One cipher round, forward or inverse, on a 128-bit state (combinational).
// Depends on maes_pkg.
module maes_round import maes_pkg::*; (
   input  logic [127:0]   state_i,
   input  logic [127:0]   round_key,
   input  round_ctrl_type ctrl,
   output logic [127:0]   state_o
);

   localparam logic [7:0] FWD_ROW [4] = '{8'd1, 8'd4, 8'd4, 8'd5};
   localparam logic [7:0] INV_ROW [4] = '{8'd165, 8'd7, 8'd26, 8'd115};

   logic [7:0] s   [16];
   logic [7:0] a   [16];
   logic [7:0] b   [16];
   logic [7:0] m   [16];
   logic [7:0] res [16];

   always_comb begin
      for (int k = 0; k < 16; k++) s[k] = state_i[127-8*k -: 8];

      if (!ctrl.decrypt) begin
         for (int k = 0; k < 16; k++) a[k] = sbox(gf_mul(s[k], 8'd2) ^ 8'h01);
         for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) b[c*4+r] = a[((c + r) & 3)*4 + r];
         end
         for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
               m[c*4+r] = 8'h00;
               for (int k = 0; k < 4; k++) begin
                  m[c*4+r] = m[c*4+r] ^ gf_mul(b[c*4+k], FWD_ROW[(k - r + 4) & 3]);
               end
            end
         end
         for (int k = 0; k < 16; k++) res[k] = ctrl.skip_mix ? b[k] : m[k];
      end else begin
         for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
               m[c*4+r] = 8'h00;
               for (int k = 0; k < 4; k++) begin
                  m[c*4+r] = m[c*4+r] ^ gf_mul(s[c*4+k], INV_ROW[(k - r + 4) & 3]);
               end
            end
         end
         for (int k = 0; k < 16; k++) a[k] = ctrl.skip_mix ? s[k] : m[k];
         for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) b[c*4+r] = a[((c - r + 4) & 3)*4 + r];
         end
         for (int k = 0; k < 16; k++) res[k] = gf_mul(inv_sbox(b[k]) ^ 8'h01, 8'd141);
      end

      for (int k = 0; k < 16; k++) begin
         state_o[127-8*k -: 8] = (ctrl.key_only ? s[k] : res[k]) ^ round_key[127-8*k -: 8];
      end
   end

endmodule

// ----- rtl/modified_aes128_block_cipher_unit.sv -----
// Top level of the modified AES-128 cipher: request/response channels,
// key registers, round-key memory and round sequencer. Uses maes_pkg, maes_round.
//
// With the key schedule current, a request runs from acceptance through the
// initial key addition and ten rounds, one per cycle on the single round unit
// (the last one holds while an earlier result is stalled), each fed by one read
// of the round-key memory. After a key write the first request also expands
// the schedule, one round key a cycle written into the memory. A finished result
// waits in the output register; the next request is taken once the unit is free.
module modified_aes128_block_cipher_unit import maes_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_EXPAND = 2'd1;
   localparam logic [1:0] ST_RUN    = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic                   ready_ff, ready_in;
   logic [63:0]            key_high_ff, key_high_in, key_low_ff, key_low_in;
   logic [127:0]           blk_ff, blk_in;
   logic                   dec_ff, dec_in;
   logic [RkAddrWidth-1:0] round_ff, round_in;
   logic [RkAddrWidth-1:0] exp_ff, exp_in;
   logic [127:0]           cur_ff, cur_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;
   logic [127:0]           rd_ff;

   logic [127:0]           sched_mem [NumRoundKeys];
   logic                   wr_en;
   logic [RkAddrWidth-1:0] wr_addr, rd_addr;
   logic [127:0]           round_out;
   round_ctrl_type         ctrl;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign ctrl.decrypt  = dec_ff;
   assign ctrl.key_only = (round_ff == '0);
   assign ctrl.skip_mix = dec_ff ? (round_ff == RkAddrWidth'(1)) : (round_ff == LastRound);

   maes_round u_round (
      .state_i  (blk_ff),
      .round_key(rd_ff),
      .ctrl     (ctrl),
      .state_o  (round_out)
   );

   always_comb begin
      state_in     = state_ff;
      ready_in     = ready_ff;
      key_high_in  = key_high_ff;
      key_low_in   = key_low_ff;
      blk_in       = blk_ff;
      dec_in       = dec_ff;
      round_in     = round_ff;
      exp_in       = exp_ff;
      cur_in       = cur_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      wr_addr      = exp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               blk_in   = {req_data.block_high, req_data.block_low};
               dec_in   = req_data.cmd;
               round_in = '0;
               if (ready_ff) begin
                  state_in = ST_RUN;
               end else begin
                  state_in = ST_EXPAND;
                  exp_in   = '0;
                  cur_in   = {key_high_ff, key_low_ff};
               end
            end
         end
         ST_EXPAND: begin
            wr_en  = 1'b1;
            cur_in = next_round_key(cur_ff, exp_ff);
            exp_in = exp_ff + RkAddrWidth'(1);
            if (exp_ff == LastRound) begin
               ready_in = 1'b1;
               state_in = ST_RUN;
               round_in = '0;
            end
         end
         ST_RUN: begin
            if (round_ff != LastRound) begin
               blk_in   = round_out;
               round_in = round_ff + RkAddrWidth'(1);
            end else if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = '{result_high: round_out[127:64], result_low: round_out[63:0]};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_write) begin
         unique case (csr_index)
            CSR_KEY_HIGH: key_high_in = csr_data;
            CSR_KEY_LOW:  key_low_in  = csr_data;
            default:      key_low_in  = key_low_ff;
         endcase
         ready_in = 1'b0;
      end

      rd_addr = key_index((state_ff == ST_IDLE) ? req_data.cmd : dec_ff, round_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ready_ff     <= 1'b0;
         key_high_ff  <= '0;
         key_low_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ready_ff     <= ready_in;
         key_high_ff  <= key_high_in;
         key_low_ff   <= key_low_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      blk_ff   <= blk_in;
      dec_ff   <= dec_in;
      round_ff <= round_in;
      exp_ff   <= exp_in;
      cur_ff   <= cur_in;
      rsp_ff   <= rsp_in;
   end

   // round-key memory, write-first forwarding on a same-address access
   always_ff @(posedge clock) begin
      if (wr_en) sched_mem[wr_addr] <= cur_ff;
      if (wr_en && (wr_addr == rd_addr)) rd_ff <= cur_ff;
      else rd_ff <= sched_mem[rd_addr];
   end

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("request accepted but unit stayed idle");

   a_key_write_clears: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> !ready_ff)
      else $error("key write did not invalidate schedule");

   a_expand_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXPAND) |-> !ready_ff)
      else $error("expanding with schedule marked ready");

   a_result_from_run: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_RUN))
      else $error("result raised outside round sequence");

endmodule
